[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pcvi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pcvi_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int MAX_FACTORS  = 4;

    localparam int BP_DEPTH = MAX_SEGMENTS + 1;
    localparam int LV_DEPTH = MAX_SEGMENTS * MAX_FACTORS;
    localparam int BP_AW    = (BP_DEPTH > 1) ? $clog2(BP_DEPTH) : 1;
    localparam int LV_AW    = (LV_DEPTH > 1) ? $clog2(LV_DEPTH) : 1;
    localparam int SEG_W    = $clog2(MAX_SEGMENTS + 1);
    localparam int FCNT_W   = $clog2(MAX_FACTORS + 1);
    localparam int FI_W     = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // request kinds
    localparam logic [1:0] KIND_BP_WR = 2'd0;
    localparam logic [1:0] KIND_LV_WR = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_COUNT = 2'd1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         slot;
        logic [1:0]         factor_index;
        logic [31:0]        time_point;
        logic signed [15:0] level;
        logic [31:0]        start_time;
        logic [31:0]        duration;
    } t_in_req;

    typedef struct packed {
        logic [1:0]         factor_out;
        logic signed [47:0] integral_value;
        logic               error;
        logic               last;
    } t_out_res;

endpackage

`default_nettype wire

[rtl/pcvi_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcvi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/piecewise_constant_vector_integral.sv]
`timescale 1ns / 1ps
`default_nettype none

// Piecewise-constant vector integral. Breakpoints (Q16.16) and per-segment
// level vectors (Q4.12, one entry per factor) are loaded through ordinary
// input requests; a breakpoint or level write returns nothing. A query
// request (start, duration) is answered by factor_count result requests,
// factor 0 first, the last one marked, each carrying the Q20.28 integral
// of that factor's level over the interval, or zero with the error flag
// when the start lies outside the timeline or the timeline runs out
// first. A query keeps the input side busy until its last result is loaded
// into the output register, and any output stall prolongs that. The busy
// time is set by the single read port of the breakpoint memory (breakpoints
// are read one at a time in the search and the walk) and by the one shared
// 33x16 multiplier, used by one factor at a time (level read, then
// multiply, then accumulate). Configuration is always ready; write it only
// while no query is in flight. Memories are not cleared: read only entries
// that were written.
module piecewise_constant_vector_integral
    import pcvi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request input
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_req               i_in_data,
    // result output
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_res                   o_out_data,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK0 = 4'd1;  // breakpoint 0 on read port
    localparam logic [3:0] S_CHKN = 4'd2;  // last breakpoint on read port
    localparam logic [3:0] S_SRCH = 4'd3;  // start segment search
    localparam logic [3:0] S_LOOP = 4'd4;  // walk decision
    localparam logic [3:0] S_LO   = 4'd5;  // segment low edge
    localparam logic [3:0] S_HI   = 4'd6;  // segment high edge
    localparam logic [3:0] S_STEP = 4'd7;  // clip span to remaining length
    localparam logic [3:0] S_MUL  = 4'd8;  // level on read port, multiply
    localparam logic [3:0] S_ACC  = 4'd9;  // accumulate product
    localparam logic [3:0] S_EMIT = 4'd10; // one result per factor

    logic [3:0] r_state, n_state;

    // configuration
    logic [SEG_W-1:0]  r_seg_count;
    logic [FCNT_W-1:0] r_fac_count;

    // query context
    logic [31:0]       r_t, n_t;
    logic [31:0]       r_rest, n_rest;     // length still to cover
    logic [31:0]       r_from, n_from;
    logic [31:0]       r_span, n_span;
    logic [31:0]       r_step, n_step;
    logic [SEG_W-1:0]  r_n, n_n;
    logic [FCNT_W-1:0] r_nf, n_nf;
    logic [SEG_W-1:0]  r_i, n_i;
    logic [SEG_W-1:0]  r_k, n_k;
    logic [FI_W-1:0]   r_fidx, n_fidx;
    logic              r_err, n_err;
    logic signed [47:0] r_prod;
    logic signed [47:0] r_acc [MAX_FACTORS];

    // output register
    logic      r_out_valid, n_out_valid;
    t_out_res  r_out_data, n_out_data;

    logic      w_in_acc;
    logic      w_acc_clr;
    logic      w_acc_add;
    logic      w_fidx_last;

    // memories
    logic             w_bp_we;
    logic [BP_AW-1:0] w_bp_raddr;
    logic [31:0]      w_bp_rdata;
    logic             w_lv_we;
    logic [LV_AW-1:0] w_lv_waddr;
    logic [LV_AW-1:0] w_lv_raddr;
    logic [15:0]      w_lv_rdata;
    logic signed [48:0] w_prod;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_fidx_last = (FCNT_W'(r_fidx) == FCNT_W'(r_nf - 1'b1));

    assign w_bp_we    = w_in_acc && (i_in_data.kind == KIND_BP_WR)
                        && (int'(i_in_data.slot) <= MAX_SEGMENTS);
    assign w_lv_we    = w_in_acc && (i_in_data.kind == KIND_LV_WR)
                        && (int'(i_in_data.slot) < MAX_SEGMENTS)
                        && (int'(i_in_data.factor_index) < MAX_FACTORS);
    assign w_lv_waddr = LV_AW'(int'(i_in_data.slot) * MAX_FACTORS
                               + int'(i_in_data.factor_index));

    pcvi_ram #(
        .WIDTH (32),
        .DEPTH (BP_DEPTH),
        .AW    (BP_AW)
    ) u_bp_ram (
        .i_clk   (i_clk),
        .i_we    (w_bp_we),
        .i_waddr (BP_AW'(i_in_data.slot)),
        .i_wdata (i_in_data.time_point),
        .i_raddr (w_bp_raddr),
        .o_rdata (w_bp_rdata)
    );

    pcvi_ram #(
        .WIDTH (16),
        .DEPTH (LV_DEPTH),
        .AW    (LV_AW)
    ) u_lv_ram (
        .i_clk   (i_clk),
        .i_we    (w_lv_we),
        .i_waddr (w_lv_waddr),
        .i_wdata (i_in_data.level),
        .i_raddr (w_lv_raddr),
        .o_rdata (w_lv_rdata)
    );

    // shared multiplier: clipped step (unsigned) times level (signed)
    assign w_prod = $signed({1'b0, r_step}) * $signed(w_lv_rdata);

    // ------------------------------------------------------------------
    // sequencer; memory read addresses come from next-state decisions so
    // that the data sits on the read port in the following state
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_t         = r_t;
        n_rest      = r_rest;
        n_from      = r_from;
        n_span      = r_span;
        n_step      = r_step;
        n_n         = r_n;
        n_nf        = r_nf;
        n_i         = r_i;
        n_k         = r_k;
        n_fidx      = r_fidx;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_acc_clr   = 1'b0;
        w_acc_add   = 1'b0;
        w_bp_raddr  = '0;
        w_lv_raddr  = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_data.kind == KIND_QUERY)) begin
                    n_t       = i_in_data.start_time;
                    n_rest    = i_in_data.duration;
                    n_n       = r_seg_count;
                    n_nf      = r_fac_count;
                    n_err     = 1'b0;
                    n_i       = '0;
                    w_acc_clr = 1'b1;
                    w_bp_raddr = '0;
                    n_state   = S_CHK0;
                end
            end
            S_CHK0: begin
                if (r_t < w_bp_rdata) begin
                    n_err   = 1'b1;
                    n_fidx  = '0;
                    n_state = S_EMIT;
                end else begin
                    w_bp_raddr = BP_AW'(r_n);
                    n_state    = S_CHKN;
                end
            end
            S_CHKN: begin
                if (r_t > w_bp_rdata) begin
                    n_err   = 1'b1;
                    n_fidx  = '0;
                    n_state = S_EMIT;
                end else if (r_n > SEG_W'(1)) begin
                    n_k        = SEG_W'(1);
                    w_bp_raddr = BP_AW'(1);
                    n_state    = S_SRCH;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_SRCH: begin
                // highest breakpoint below the last that is at most the start
                if (w_bp_rdata <= r_t) begin
                    n_i = r_k;
                end
                if (r_k == r_n - 1'b1) begin
                    n_state = S_LOOP;
                end else begin
                    n_k        = r_k + 1'b1;
                    w_bp_raddr = BP_AW'(r_k + 1'b1);
                end
            end
            S_LOOP: begin
                if ((r_rest != '0) && (r_i < r_n)) begin
                    w_bp_raddr = BP_AW'(r_i);
                    n_state    = S_LO;
                end else begin
                    n_err   = (r_rest != '0);
                    n_fidx  = '0;
                    n_state = S_EMIT;
                end
            end
            S_LO: begin
                n_from     = (r_t > w_bp_rdata) ? r_t : w_bp_rdata;
                w_bp_raddr = BP_AW'(r_i + 1'b1);
                n_state    = S_HI;
            end
            S_HI: begin
                // a reversed segment contributes nothing
                n_span  = (w_bp_rdata > r_from) ? (w_bp_rdata - r_from) : '0;
                n_state = S_STEP;
            end
            S_STEP: begin
                n_step     = (r_span > r_rest) ? r_rest : r_span;
                n_rest     = r_rest - ((r_span > r_rest) ? r_rest : r_span);
                n_fidx     = '0;
                w_lv_raddr = LV_AW'(int'(r_i) * MAX_FACTORS);
                n_state    = S_MUL;
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                w_acc_add = 1'b1;
                if (w_fidx_last) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_LOOP;
                end else begin
                    n_fidx     = r_fidx + 1'b1;
                    w_lv_raddr = LV_AW'(int'(r_i) * MAX_FACTORS + int'(r_fidx) + 1);
                    n_state    = S_MUL;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid                = 1'b1;
                    n_out_data.factor_out      = 2'(r_fidx);
                    n_out_data.integral_value  = r_err ? '0 : r_acc[r_fidx];
                    n_out_data.error           = r_err;
                    n_out_data.last            = w_fidx_last;
                    if (w_fidx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_fidx = r_fidx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_nf        <= FCNT_W'(1);
            r_fidx      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_nf        <= n_nf;
            r_fidx      <= n_fidx;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_t        <= n_t;
        r_rest     <= n_rest;
        r_from     <= n_from;
        r_span     <= n_span;
        r_step     <= n_step;
        r_n        <= n_n;
        r_i        <= n_i;
        r_k        <= n_k;
        r_err      <= n_err;
        r_out_data <= n_out_data;
        r_prod     <= 48'(w_prod);
        if (w_acc_clr) begin
            for (int j = 0; j < MAX_FACTORS; j++) begin
                r_acc[j] <= '0;
            end
        end else if (w_acc_add) begin
            r_acc[r_fidx] <= r_acc[r_fidx] + r_prod;
        end
    end

    // configuration registers, saturated into their legal ranges
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= SEG_W'(1);
            r_fac_count <= FCNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SEG_COUNT: begin
                    if (i_cfg_data[4:0] == 5'd0) begin
                        r_seg_count <= SEG_W'(1);
                    end else if (int'(i_cfg_data[4:0]) > MAX_SEGMENTS) begin
                        r_seg_count <= SEG_W'(MAX_SEGMENTS);
                    end else begin
                        r_seg_count <= SEG_W'(i_cfg_data[4:0]);
                    end
                end
                CFG_FACTOR_COUNT: begin
                    if (i_cfg_data[2:0] == 3'd0) begin
                        r_fac_count <= FCNT_W'(1);
                    end else if (int'(i_cfg_data[2:0]) > MAX_FACTORS) begin
                        r_fac_count <= FCNT_W'(MAX_FACTORS);
                    end else begin
                        r_fac_count <= FCNT_W'(i_cfg_data[2:0]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // an error result never carries a value
    `ASSERT_IMPL(a_err_zero, i_clk, i_rst_n,
        r_out_valid && r_out_data.error, r_out_data.integral_value == '0,
        "error result with non-zero integral")

    // the marked result is the one of the highest factor in use
    `ASSERT_IMPL(a_last_factor, i_clk, i_rst_n,
        r_out_valid && r_out_data.last,
        r_out_data.factor_out == 2'(r_nf - 1'b1),
        "last flag on wrong factor")

    // a query holds off further requests
    `ASSERT_NEXT(a_query_busy, i_clk, i_rst_n,
        w_in_acc && (i_in_data.kind == KIND_QUERY), !o_in_ready,
        "request accepted during query")

endmodule

`default_nettype wire
